@@ rtl/lobm_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lobm_pkg
// Shared types and codes of the limit order book matcher.
// -----------------------------------------------------------------------------
package lobm_pkg;

   localparam int PTR_W = 7;
   localparam logic [PTR_W-1:0] NIL_PTR = 7'h7f;

   localparam logic [2:0] OUT_FILLED    = 3'd0;
   localparam logic [2:0] OUT_RESTED    = 3'd1;
   localparam logic [2:0] OUT_DROPPED   = 3'd2;
   localparam logic [2:0] OUT_POOL_FULL = 3'd3;
   localparam logic [2:0] OUT_CANCELLED = 3'd4;
   localparam logic [2:0] OUT_NOT_FOUND = 3'd5;

   localparam logic [3:0] CSR_REF_PRICE = 4'd0;
   localparam logic [3:0] CSR_TICK      = 4'd1;

   localparam logic ACT_SUBMIT = 1'b0;

   typedef struct packed {
      logic [31:0]      id;
      logic [31:0]      price;
      logic [31:0]      remaining;
      logic [PTR_W-1:0] next;
   } slot_entry_type;

   typedef struct packed {
      logic             body_we;
      logic             next_we;
      logic [PTR_W-1:0] addr;
      slot_entry_type   data;
   } slot_wr_type;

endpackage

@@ rtl/lobm_level_unit.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lobm_level_unit
// Maps a price to its book level with a bit-serial divider, one quotient bit
// per cycle, followed by a clamp to the level range.
// -----------------------------------------------------------------------------
module lobm_level_unit #(
   parameter int PRICE_LEVELS = 256,
   parameter int LVL_W = $clog2(PRICE_LEVELS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      price,
   input  logic [31:0]      base_price,
   input  logic [15:0]      tick,
   output logic             done,
   output logic [LVL_W-1:0] level
);
   localparam int HALF = PRICE_LEVELS / 2;
   localparam int UPMAX = PRICE_LEVELS - 1 - HALF;

   logic             busy_ff, done_ff, neg_ff;
   logic [4:0]       cnt_ff;
   logic [31:0]      dvd_ff, quo_ff;
   logic [15:0]      rem_ff, step_ff;
   logic [LVL_W-1:0] level_ff;
   logic [16:0]      trial;
   logic             ge;
   logic [31:0]      quo_in;
   logic [LVL_W-1:0] level_in;

   always_comb begin
      trial = {rem_ff, dvd_ff[31]};
      ge = trial >= {1'b0, step_ff};
      quo_in = {quo_ff[30:0], ge};
      if (neg_ff) begin
         level_in = (quo_in > 32'(HALF)) ? '0 : LVL_W'(32'(HALF) - quo_in);
      end else begin
         level_in = (quo_in > 32'(UPMAX)) ? LVL_W'(PRICE_LEVELS - 1)
                                          : LVL_W'(32'(HALF) + quo_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= price < base_price;
         dvd_ff <= (price < base_price) ? (base_price - price) : (price - base_price);
         step_ff <= (tick == 16'd0) ? 16'd1 : tick;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[30:0], 1'b0};
         rem_ff <= ge ? 16'(trial - {1'b0, step_ff}) : trial[15:0];
         quo_ff <= quo_in;
         if (cnt_ff == 5'd31) begin
            level_ff <= level_in;
         end
      end
   end

   assign done = done_ff;
   assign level = level_ff;

endmodule

@@ rtl/lobm_head_mem.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lobm_head_mem
// Level head pointers of both sides, one write and one registered read port.
// -----------------------------------------------------------------------------
module lobm_head_mem #(
   parameter int DEPTH = 512,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       re,
   input  logic [AW-1:0]              raddr,
   output logic [lobm_pkg::PTR_W-1:0] rdata,
   input  logic                       we,
   input  logic [AW-1:0]              waddr,
   input  logic [lobm_pkg::PTR_W-1:0] wdata
);
   import lobm_pkg::*;

   logic [PTR_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/lobm_slot_mem.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lobm_slot_mem
// Order slot pool: id, price, remaining quantity and list link per slot.
// -----------------------------------------------------------------------------
module lobm_slot_mem #(
   parameter int POOL_ENTRIES = 64,
   parameter int SLOT_W = $clog2(POOL_ENTRIES)
) (
   input  logic                       clock,
   input  logic                       re,
   input  logic [lobm_pkg::PTR_W-1:0] raddr,
   output lobm_pkg::slot_entry_type   rdata,
   input  lobm_pkg::slot_wr_type      wr
);
   import lobm_pkg::*;

   logic [31:0]      id_mem    [POOL_ENTRIES];
   logic [31:0]      price_mem [POOL_ENTRIES];
   logic [31:0]      rem_mem   [POOL_ENTRIES];
   logic [PTR_W-1:0] next_mem  [POOL_ENTRIES];
   slot_entry_type   rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.body_we) begin
         id_mem[wr.addr[SLOT_W-1:0]] <= wr.data.id;
         price_mem[wr.addr[SLOT_W-1:0]] <= wr.data.price;
         rem_mem[wr.addr[SLOT_W-1:0]] <= wr.data.remaining;
      end
      if (wr.next_we) begin
         next_mem[wr.addr[SLOT_W-1:0]] <= wr.data.next;
      end
      if (re) begin
         rdata_ff.id <= id_mem[raddr[SLOT_W-1:0]];
         rdata_ff.price <= price_mem[raddr[SLOT_W-1:0]];
         rdata_ff.remaining <= rem_mem[raddr[SLOT_W-1:0]];
         rdata_ff.next <= next_mem[raddr[SLOT_W-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/limit_order_book_matcher.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book over a slot pool with per-level FIFO lists.
// -----------------------------------------------------------------------------
// A submit passes through the level divider, scans levels and touches resting orders, then
// finishes, or rests the remainder at the tail of its level's queue. A cancel walks the
// levels of both sides and their slots. Response stalls hold the matcher.
// One item is in flight at a time.
// Reset clears control state, then a sweep over the head table and slot pool
// initializes heads and the free list before req_ready.
module limit_order_book_matcher #(
   parameter int POOL_ENTRIES = 64,
   parameter int PRICE_LEVELS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_order_id,
   input  logic        req_side,
   input  logic [31:0] req_price,
   input  logic [31:0] req_quantity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_fill,
   output logic [31:0] rsp_resting_id,
   output logic [31:0] rsp_taker_id,
   output logic [31:0] rsp_fill_qty,
   output logic [31:0] rsp_fill_price,
   output logic [31:0] rsp_exec_number,
   output logic [6:0]  rsp_fill_count,
   output logic [2:0]  rsp_outcome,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);
   import lobm_pkg::*;

   localparam int LVL_W = $clog2(PRICE_LEVELS);
   localparam int KW = $clog2(PRICE_LEVELS + 1);
   localparam int HDEPTH = 2 * PRICE_LEVELS;
   localparam int HAW = LVL_W + 1;
   localparam int SWEEP = (HDEPTH > POOL_ENTRIES) ? HDEPTH : POOL_ENTRIES;
   localparam int CW = $clog2(SWEEP);
   localparam logic [PTR_W-1:0] POOL_PTR = PTR_W'(POOL_ENTRIES);

   typedef enum logic [14:0] {
      S_CLEAR  = 15'b000000000000001,
      S_IDLE   = 15'b000000000000010,
      S_DIV    = 15'b000000000000100,
      S_SCAN   = 15'b000000000001000,
      S_HWAIT  = 15'b000000000010000,
      S_SWAIT  = 15'b000000000100000,
      S_FIN    = 15'b000000001000000,
      S_RFREE  = 15'b000000010000000,
      S_RHEAD  = 15'b000000100000000,
      S_RWALK  = 15'b000001000000000,
      S_CHEAD  = 15'b000010000000000,
      S_CHWAIT = 15'b000100000000000,
      S_CWALK  = 15'b001000000000000,
      S_CFREE  = 15'b010000000000000,
      S_DONE   = 15'b100000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    clr_ff, clr_in;
   logic [31:0]      ref_ff, id_ff, id_in, price_ff, price_in, rem_ff, rem_in;
   logic [15:0]      tick_ff;
   logic             side_ff, side_in, cside_ff, cside_in;
   logic [LVL_W-1:0] lim_ff, lim_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [PTR_W-1:0] cur_ff, cur_in, prev_ff, prev_in, free_ff, free_in;
   logic [PTR_W-1:0] new_ff, new_in;
   logic [6:0]       nfill_ff, nfill_in;
   logic [2:0]       outc_ff, outc_in;
   logic [31:0]      seq_ff, seq_in;
   logic             pend_ff, pend_in;
   logic [31:0]      prid_ff, prid_in, pqty_ff, pqty_in, pprice_ff, pprice_in;
   logic [31:0]      pexec_ff, pexec_in;
   logic             rv_ff, rv_in, rhf_ff, rhf_in, rlast_ff, rlast_in;
   logic [31:0]      rrid_ff, rrid_in, rtid_ff, rtid_in, rqty_ff, rqty_in;
   logic [31:0]      rprice_ff, rprice_in, rexec_ff, rexec_in;
   logic [6:0]       rcnt_ff, rcnt_in;
   logic [2:0]       routc_ff, routc_in;

   logic             div_start, div_done;
   logic [LVL_W-1:0] div_level, scan_lvl;
   logic             head_re, head_we;
   logic [HAW-1:0]   head_raddr, head_waddr;
   logic [PTR_W-1:0] head_q, head_wdata;
   logic             slot_re;
   logic [PTR_W-1:0] slot_raddr;
   slot_entry_type   slot_q;
   slot_wr_type      slot_wr;
   logic             out_free, accept, market, crossed;
   logic [31:0]      fq, rem_left;

   lobm_level_unit #(.PRICE_LEVELS(PRICE_LEVELS), .LVL_W(LVL_W)) u_level (
      .clock(clock), .reset(reset), .start(div_start), .price(price_ff),
      .base_price(ref_ff), .tick(tick_ff), .done(div_done), .level(div_level)
   );

   lobm_head_mem #(.DEPTH(HDEPTH), .AW(HAW)) u_heads (
      .clock(clock), .re(head_re), .raddr(head_raddr), .rdata(head_q),
      .we(head_we), .waddr(head_waddr), .wdata(head_wdata)
   );

   lobm_slot_mem #(.POOL_ENTRIES(POOL_ENTRIES)) u_slots (
      .clock(clock), .re(slot_re), .raddr(slot_raddr), .rdata(slot_q), .wr(slot_wr)
   );

   assign out_free = !rv_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign market = (price_ff == 32'd0);
   assign scan_lvl = side_ff ? (LVL_W'(PRICE_LEVELS - 1) - k_ff[LVL_W-1:0])
                             : k_ff[LVL_W-1:0];
   assign crossed = side_ff ? (scan_lvl < lim_ff) : (scan_lvl > lim_ff);
   assign fq = (rem_ff < slot_q.remaining) ? rem_ff : slot_q.remaining;
   assign rem_left = rem_ff - fq;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; id_in = id_ff; price_in = price_ff;
      rem_in = rem_ff; side_in = side_ff; cside_in = cside_ff; lim_in = lim_ff;
      k_in = k_ff; cur_in = cur_ff; prev_in = prev_ff; free_in = free_ff;
      new_in = new_ff; nfill_in = nfill_ff; outc_in = outc_ff; seq_in = seq_ff;
      pend_in = pend_ff; prid_in = prid_ff; pqty_in = pqty_ff;
      pprice_in = pprice_ff; pexec_in = pexec_ff;
      rv_in = rv_ff && !rsp_ready; rhf_in = rhf_ff; rlast_in = rlast_ff;
      rrid_in = rrid_ff; rtid_in = rtid_ff; rqty_in = rqty_ff;
      rprice_in = rprice_ff; rexec_in = rexec_ff; rcnt_in = rcnt_ff;
      routc_in = routc_ff;
      div_start = 1'b0;
      head_re = 1'b0; head_raddr = {~side_ff, scan_lvl};
      head_we = 1'b0; head_waddr = {~side_ff, scan_lvl}; head_wdata = slot_q.next;
      slot_re = 1'b0; slot_raddr = slot_q.next;
      slot_wr = '0;
      slot_wr.addr = cur_ff;
      slot_wr.data = slot_q;
      slot_wr.data.next = free_ff;

      unique case (state_ff)
         S_CLEAR: begin
            head_we = ({1'b0, clr_ff} < (CW + 1)'(HDEPTH));
            head_waddr = HAW'(clr_ff);
            head_wdata = NIL_PTR;
            slot_wr.next_we = ({1'b0, clr_ff} < (CW + 1)'(POOL_ENTRIES));
            slot_wr.addr = PTR_W'(clr_ff);
            slot_wr.data.next = ({1'b0, clr_ff} + 1'b1 < (CW + 1)'(POOL_ENTRIES))
                                ? PTR_W'(clr_ff + 1'b1) : NIL_PTR;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(SWEEP - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               id_in = req_order_id; price_in = req_price; side_in = req_side;
               rem_in = req_quantity; nfill_in = '0; pend_in = 1'b0;
               k_in = '0; cside_in = 1'b0;
               state_in = (req_action == ACT_SUBMIT) ? S_DIV : S_CHEAD;
            end
         end
         S_DIV: begin
            div_start = (k_ff == '0) && !div_done;
            k_in = KW'(1);
            if (div_done) begin
               lim_in = div_level;
               k_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (k_ff >= KW'(PRICE_LEVELS) || rem_ff == 32'd0 || (!market && crossed)) begin
               state_in = S_FIN;
            end else begin
               head_re = 1'b1;
               state_in = S_HWAIT;
            end
         end
         S_HWAIT: begin
            if (head_q >= POOL_PTR) begin
               k_in = k_ff + 1'b1;
               state_in = S_SCAN;
            end else begin
               cur_in = head_q;
               slot_re = 1'b1;
               slot_raddr = head_q;
               state_in = S_SWAIT;
            end
         end
         S_SWAIT: begin
            if (out_free) begin
               if (pend_ff) begin
                  rv_in = 1'b1; rhf_in = 1'b1; rlast_in = 1'b0;
                  rrid_in = prid_ff; rtid_in = id_ff; rqty_in = pqty_ff;
                  rprice_in = pprice_ff; rexec_in = pexec_ff;
                  rcnt_in = '0; routc_in = OUT_FILLED;
               end
               pend_in = 1'b1; prid_in = slot_q.id; pqty_in = fq;
               pprice_in = slot_q.price; pexec_in = seq_ff;
               seq_in = seq_ff + 32'd1;
               nfill_in = nfill_ff + 7'd1;
               rem_in = rem_left;
               if (slot_q.remaining == fq) begin
                  head_we = 1'b1;
                  slot_wr.next_we = 1'b1;
                  free_in = cur_ff;
                  if (rem_left != 32'd0 && slot_q.next < POOL_PTR) begin
                     cur_in = slot_q.next;
                     slot_re = 1'b1;
                  end else if (rem_left != 32'd0) begin
                     k_in = k_ff + 1'b1;
                     state_in = S_SCAN;
                  end else begin
                     state_in = S_FIN;
                  end
               end else begin
                  slot_wr.body_we = 1'b1;
                  slot_wr.data.remaining = slot_q.remaining - fq;
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (rem_ff == 32'd0) begin
               outc_in = OUT_FILLED;
               state_in = S_DONE;
            end else if (market) begin
               outc_in = OUT_DROPPED;
               state_in = S_DONE;
            end else if (free_ff >= POOL_PTR) begin
               outc_in = OUT_POOL_FULL;
               state_in = S_DONE;
            end else begin
               slot_re = 1'b1;
               slot_raddr = free_ff;
               new_in = free_ff;
               state_in = S_RFREE;
            end
         end
         S_RFREE: begin
            free_in = slot_q.next;
            slot_wr.body_we = 1'b1;
            slot_wr.next_we = 1'b1;
            slot_wr.addr = new_ff;
            slot_wr.data.id = id_ff;
            slot_wr.data.price = price_ff;
            slot_wr.data.remaining = rem_ff;
            slot_wr.data.next = NIL_PTR;
            head_re = 1'b1;
            head_raddr = {side_ff, lim_ff};
            state_in = S_RHEAD;
         end
         S_RHEAD: begin
            if (head_q >= POOL_PTR) begin
               head_we = 1'b1;
               head_waddr = {side_ff, lim_ff};
               head_wdata = new_ff;
               outc_in = OUT_RESTED;
               state_in = S_DONE;
            end else begin
               cur_in = head_q;
               slot_re = 1'b1;
               slot_raddr = head_q;
               state_in = S_RWALK;
            end
         end
         S_RWALK: begin
            if (slot_q.next >= POOL_PTR) begin
               slot_wr.next_we = 1'b1;
               slot_wr.data.next = new_ff;
               outc_in = OUT_RESTED;
               state_in = S_DONE;
            end else begin
               cur_in = slot_q.next;
               slot_re = 1'b1;
            end
         end
         S_CHEAD: begin
            if (k_ff >= KW'(PRICE_LEVELS)) begin
               k_in = '0;
               if (!cside_ff) begin
                  cside_in = 1'b1;
               end else begin
                  outc_in = OUT_NOT_FOUND;
                  state_in = S_DONE;
               end
            end else begin
               head_re = 1'b1;
               head_raddr = {cside_ff, k_ff[LVL_W-1:0]};
               prev_in = NIL_PTR;
               state_in = S_CHWAIT;
            end
         end
         S_CHWAIT: begin
            if (head_q >= POOL_PTR) begin
               k_in = k_ff + 1'b1;
               state_in = S_CHEAD;
            end else begin
               cur_in = head_q;
               slot_re = 1'b1;
               slot_raddr = head_q;
               state_in = S_CWALK;
            end
         end
         S_CWALK: begin
            if (slot_q.id == id_ff) begin
               if (prev_ff == NIL_PTR) begin
                  head_we = 1'b1;
                  head_waddr = {cside_ff, k_ff[LVL_W-1:0]};
                  slot_wr.next_we = 1'b1;
                  free_in = cur_ff;
                  outc_in = OUT_CANCELLED;
                  state_in = S_DONE;
               end else begin
                  slot_wr.next_we = 1'b1;
                  slot_wr.addr = prev_ff;
                  slot_wr.data.next = slot_q.next;
                  state_in = S_CFREE;
               end
            end else begin
               prev_in = cur_ff;
               if (slot_q.next >= POOL_PTR) begin
                  k_in = k_ff + 1'b1;
                  state_in = S_CHEAD;
               end else begin
                  cur_in = slot_q.next;
                  slot_re = 1'b1;
               end
            end
         end
         S_CFREE: begin
            slot_wr.next_we = 1'b1;
            free_in = cur_ff;
            outc_in = OUT_CANCELLED;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rv_in = 1'b1; rlast_in = 1'b1; routc_in = outc_ff;
               rtid_in = id_ff; rhf_in = pend_ff;
               rcnt_in = pend_ff ? nfill_ff : 7'd0;
               rrid_in = pend_ff ? prid_ff : 32'd0;
               rqty_in = pend_ff ? pqty_ff : 32'd0;
               rprice_in = pend_ff ? pprice_ff : 32'd0;
               rexec_in = pend_ff ? pexec_ff : 32'd0;
               pend_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         free_ff <= '0;
         seq_ff <= '0;
         pend_ff <= 1'b0;
         rv_ff <= 1'b0;
         k_ff <= '0;
         nfill_ff <= '0;
         ref_ff <= '0;
         tick_ff <= 16'd1;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         free_ff <= free_in;
         seq_ff <= seq_in;
         pend_ff <= pend_in;
         rv_ff <= rv_in;
         k_ff <= k_in;
         nfill_ff <= nfill_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_REF_PRICE: ref_ff <= csr_data;
               CSR_TICK: tick_ff <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in; price_ff <= price_in; rem_ff <= rem_in; side_ff <= side_in;
      cside_ff <= cside_in; lim_ff <= lim_in; cur_ff <= cur_in; prev_ff <= prev_in;
      new_ff <= new_in; outc_ff <= outc_in;
      prid_ff <= prid_in; pqty_ff <= pqty_in; pprice_ff <= pprice_in;
      pexec_ff <= pexec_in;
      rhf_ff <= rhf_in; rlast_ff <= rlast_in; rrid_ff <= rrid_in; rtid_ff <= rtid_in;
      rqty_ff <= rqty_in; rprice_ff <= rprice_in; rexec_ff <= rexec_in;
      rcnt_ff <= rcnt_in; routc_ff <= routc_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_has_fill = rhf_ff;
   assign rsp_resting_id = rrid_ff;
   assign rsp_taker_id = rtid_ff;
   assign rsp_fill_qty = rqty_ff;
   assign rsp_fill_price = rprice_ff;
   assign rsp_exec_number = rexec_ff;
   assign rsp_fill_count = rcnt_ff;
   assign rsp_outcome = routc_ff;
   assign rsp_last = rlast_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_ff)
      else $error("pending fill left over at idle");

   a_free_head_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |-> (free_ff < POOL_PTR || free_ff == NIL_PTR))
      else $error("free list head out of range");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |-> (nfill_ff <= 7'(POOL_ENTRIES)))
      else $error("more fills than pool slots");

   a_done_emits_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rv_ff && rlast_ff && state_ff == S_IDLE))
      else $error("final beat not presented");

endmodule
